// ===== rtl/psgp_pkg.sv =====
// shared types, constants and tables for the position-specific gap penalty block
`timescale 1ns / 1ps
package psgp_pkg;

  // profile limits
  localparam int MAX_SEQ    = 64;
  localparam int SEQ_W      = $clog2(MAX_SEQ + 1);
  localparam int SEQ_AW     = $clog2(MAX_SEQ);
  localparam int MAX_COLS   = 4096;
  localparam int COL_W      = $clog2(MAX_COLS);

  // rule windows
  localparam int NEAR_REACH = 8;
  localparam int SPAN       = 5;
  localparam int DELAY      = (NEAR_REACH > SPAN - 1) ? NEAR_REACH : SPAN - 1;
  localparam int HOLD       = DELAY + 1;
  localparam int WIN        = DELAY + NEAR_REACH + 1;
  localparam int FLUSH_W    = $clog2(DELAY + 1);
  localparam int NEAR_W     = $clog2(NEAR_REACH + 1);
  localparam int RUN_W      = $clog2(SPAN + 1);

  // arithmetic widths
  localparam int PEN_W      = 16;
  localparam int FACT_W     = 9;
  localparam int FSUM_W     = 15;
  localparam int MUL_W      = 15;
  localparam int DEN_W      = 15;
  localparam int PROD_W     = PEN_W + MUL_W;
  localparam int QUO_W      = 18;
  localparam int REM_W      = DEN_W;
  localparam int CNT_W      = $clog2(QUO_W);

  // rule scale factors
  localparam int GAP_NUM     = 3;
  localparam int GAP_DEN     = 10;
  localparam int STRETCH_NUM = 2;
  localparam int STRETCH_DEN = 3;
  localparam int FACT_SHIFT  = 8;

  // residue characters
  localparam logic [7:0] CH_GAP = 8'h2D;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_Z   = 8'h5A;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYDRO      = 2'd2;
  localparam int HYD_W = 26;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int OUT_DW  = 48;

  // one classified residue
  typedef struct packed {
    logic              gap;
    logic              hydro;
    logic [FACT_W-1:0] factor;
    logic              col_end;
    logic              prof_end;
  } item_t;

  // per-residue factor, Q1.8
  function automatic logic [FACT_W-1:0] factor_of(input logic [4:0] k);
    logic [FACT_W-1:0] f;
    begin
      case (k)
        5'd0:  f = 9'd289;
        5'd2:  f = 9'd289;
        5'd3:  f = 9'd246;
        5'd4:  f = 9'd335;
        5'd5:  f = 9'd307;
        5'd6:  f = 9'd156;
        5'd7:  f = 9'd256;
        5'd8:  f = 9'd338;
        5'd10: f = 9'd246;
        5'd11: f = 9'd310;
        5'd12: f = 9'd330;
        5'd13: f = 9'd161;
        5'd15: f = 9'd189;
        5'd16: f = 9'd274;
        5'd17: f = 9'd184;
        5'd18: f = 9'd195;
        5'd19: f = 9'd228;
        5'd21: f = 9'd320;
        5'd22: f = 9'd315;
        5'd24: f = 9'd256;
        default: f = '0;
      endcase
      return f;
    end
  endfunction

endpackage

// ===== rtl/position_specific_gap_penalty_unit.sv =====
// top level of the position-specific gap penalty block
`timescale 1ns / 1ps
// Usage:
//   in_*  : one residue per transaction, in_tdata = ASCII letter ('-' is a gap),
//           in_tuser = last sequence of the column, in_tlast = end of profile.
//   out_* : one transaction per column, in column order, eight columns behind
//           the input; out_tlast marks the final column of the profile.
//   cfg_* : register writes (0 gap open, 1 gap extend, 2 hydrophilic letter
//           mask), always ready; write only while no transaction is in flight.
// Back end: a residue passes the idle and update states; closing a column adds
//   the column close, rule select, one multiply, a restoring divide of the
//   18-bit quotient, output load and next step. A profile end emits up to 9 columns.
// A 4-entry queue lets residues keep coming while the back end computes.
// Latency: a column's penalties leave once 8 later columns have closed, or
//   at the profile end.
// Reset clears the stream control state and loads the register defaults. When the
//   receiver stalls, the output register holds; the queue fills and in_tready
//   drops.
module position_specific_gap_penalty_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] residue
  input  logic                              in_tuser,   // [0] column_end
  input  logic                              in_tlast,   // profile_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] column_index, [27:12] open_penalty, [43:28] extend_penalty, zero pad
  output logic [psgp_pkg::OUT_DW-1:0]       out_tdata,
  output logic                              out_tlast,  // last_column
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psgp_pkg::HYD_W-1:0]        cfg_data
);
  import psgp_pkg::*;

  logic [PEN_W-1:0] gap_open_r, gap_extend_r;
  logic [HYD_W-1:0] hydro_r;
  logic             q_full, q_push, q_pop, q_valid;
  item_t            push_item, pop_item;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r   <= PEN_W'(2560);
      gap_extend_r <= PEN_W'(51);
      hydro_r      <= HYD_W'(500824);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAP_OPEN:   gap_open_r   <= cfg_data[PEN_W-1:0];
        REG_GAP_EXTEND: gap_extend_r <= cfg_data[PEN_W-1:0];
        REG_HYDRO:      hydro_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  psgp_front u_front (
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .hydro_letters (hydro_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  psgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  psgp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .gap_open   (gap_open_r),
    .gap_extend (gap_extend_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/psgp_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module psgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/psgp_front.sv =====
// input side: accepts residues and classifies them for the back end
`timescale 1ns / 1ps
module psgp_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // residue
  input  logic                         in_tuser,   // column_end
  input  logic                         in_tlast,   // profile_end
  input  logic [psgp_pkg::HYD_W-1:0]   hydro_letters,
  input  logic                         q_full,
  output logic                         q_push,
  output psgp_pkg::item_t              q_item
);
  import psgp_pkg::*;

  logic       is_letter;
  logic [7:0] letter_ofs;
  logic [4:0] letter_k;

  // letter decode
  assign is_letter  = (in_tdata >= CH_A) && (in_tdata <= CH_Z);
  assign letter_ofs = in_tdata - CH_A;
  assign letter_k   = letter_ofs[4:0];

  // handshake
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // classification
  always_comb begin
    q_item.gap      = (in_tdata == CH_GAP);
    q_item.hydro    = is_letter && hydro_letters[letter_k];
    q_item.factor   = is_letter ? factor_of(letter_k) : '0;
    q_item.col_end  = in_tuser;
    q_item.prof_end = in_tlast;
  end

endmodule

// ===== rtl/psgp_queue.sv =====
// short fifo of classified residues between front and back
`timescale 1ns / 1ps
module psgp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psgp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output psgp_pkg::item_t pop_item
);
  import psgp_pkg::*;

  item_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = slot_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue fill level out of range");
`endif

endmodule

// ===== rtl/psgp_back.sv =====
// back end: column accumulation, stretch runs, rule selection and penalty divider
`timescale 1ns / 1ps
module psgp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  psgp_pkg::item_t              q_item,
  output logic                         q_pop,
  input  logic [psgp_pkg::PEN_W-1:0]   gap_open,
  input  logic [psgp_pkg::PEN_W-1:0]   gap_extend,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [psgp_pkg::OUT_DW-1:0]  out_tdata,
  output logic                         out_tlast
);
  import psgp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_CLOSE, S_EVAL, S_MUL, S_DIV, S_OUT, S_NEXT
  } state_t;

  state_t              state_r;
  item_t               item_r;
  logic [SEQ_W-1:0]    seq_r, gaps_r;
  logic [FSUM_W-1:0]   fsum_r;
  logic                hit_r;
  logic [MAX_SEQ-1:0]  upd_cur_r, upd_prev_r;

  // column history, index = age in columns
  logic [WIN-1:0]      gap_vec_r;
  logic [HOLD-1:0]     real_r, last_r, hit_vec_r;
  logic [SEQ_W-1:0]    n_ring_r [HOLD];
  logic [SEQ_W-1:0]    g_ring_r [HOLD];
  logic [FSUM_W-1:0]   fs_ring_r [HOLD];

  logic [FLUSH_W-1:0]  flush_r;
  logic                flushing_r;
  logic [MUL_W-1:0]    m_r;
  logic [DEN_W-1:0]    den_r;
  logic [PEN_W-1:0]    ext_r;
  logic                lastc_r;
  logic [REM_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [COL_W-1:0]    col_r;
  logic                out_valid_r, out_last_r;
  logic [OUT_DW-1:0]   out_data_r;

  // run-length ram, one entry per sequence
  logic [SEQ_AW-1:0]   seq_idx;
  logic                seq_act, ram_we;
  logic [RUN_W-1:0]    ram_rdata, prev_run, run_nxt;

  assign seq_idx  = seq_r[SEQ_AW-1:0];
  assign seq_act  = seq_r < SEQ_W'(MAX_SEQ);
  assign prev_run = upd_prev_r[seq_idx] ? ram_rdata : '0;
  assign run_nxt  = !item_r.hydro ? '0 :
                    (prev_run >= RUN_W'(SPAN)) ? RUN_W'(SPAN) : prev_run + 1'b1;
  assign ram_we   = (state_r == S_UPD) && seq_act;

  psgp_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SEQ)) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_idx),
    .wdata (run_nxt),
    .raddr (seq_idx),
    .rdata (ram_rdata)
  );

  // nearest gap within reach of the column at the emit age
  logic              near_found;
  logic [NEAR_W-1:0] near_d;
  always_comb begin
    near_found = 1'b0;
    near_d     = '0;
    for (int d = NEAR_REACH; d >= 1; d--) begin
      if (gap_vec_r[DELAY-d] || gap_vec_r[DELAY+d]) begin
        near_found = 1'b1;
        near_d     = NEAR_W'(d);
      end
    end
  end

  logic stretch_hit;
  assign stretch_hit = |hit_vec_r[DELAY -: SPAN];

  // rule selection for the column at the emit age
  logic [SEQ_W-1:0] ga, na;
  logic [MUL_W-1:0] eval_m;
  logic [DEN_W-1:0] eval_den;
  logic [PEN_W-1:0] eval_ext;
  always_comb begin
    ga       = g_ring_r[DELAY];
    na       = n_ring_r[DELAY];
    eval_m   = '0;
    eval_den = DEN_W'(1);
    eval_ext = gap_extend;
    if (ga != '0) begin
      eval_ext = gap_extend >> 1;
      if (na != '0 && ga <= na) begin
        eval_m   = MUL_W'(na - ga) * MUL_W'(GAP_NUM);
        eval_den = DEN_W'(na) * DEN_W'(GAP_DEN);
      end
    end else if (near_found) begin
      eval_m   = MUL_W'(4 * NEAR_REACH) - (MUL_W'(near_d) << 1);
      eval_den = DEN_W'(NEAR_REACH);
    end else if (stretch_hit) begin
      eval_m   = MUL_W'(STRETCH_NUM);
      eval_den = DEN_W'(STRETCH_DEN);
    end else if (na != '0) begin
      eval_m   = MUL_W'(fs_ring_r[DELAY]);
      eval_den = DEN_W'(na) << FACT_SHIFT;
    end
  end

  // multiply and divider step
  logic [PROD_W-1:0] prod;
  logic [REM_W:0]    div_sh, div_diff;
  logic              div_ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [PEN_W-1:0]  open_sat;
  assign prod     = gap_open * m_r;
  assign div_sh   = {rem_r, quo_r[QUO_W-1]};
  assign div_ge   = div_sh >= {1'b0, den_r};
  assign div_diff = div_sh - {1'b0, den_r};
  assign rem_nxt  = div_ge ? div_diff[REM_W-1:0] : div_sh[REM_W-1:0];
  assign open_sat = (|quo_r[QUO_W-1:PEN_W]) ? {PEN_W{1'b1}} : quo_r[PEN_W-1:0];

  logic out_free, out_valid_nxt;
  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = ((state_r == S_OUT) && out_free) || (out_valid_r && !out_tready);
  assign q_pop         = (state_r == S_IDLE) && q_valid;

  // sequencer, history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      gaps_r      <= '0;
      fsum_r      <= '0;
      hit_r       <= 1'b0;
      upd_cur_r   <= '0;
      upd_prev_r  <= '0;
      gap_vec_r   <= '0;
      real_r      <= '0;
      hit_vec_r   <= '0;
      flush_r     <= '0;
      flushing_r  <= 1'b0;
      cnt_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (seq_act) begin
            seq_r              <= seq_r + 1'b1;
            gaps_r             <= gaps_r + SEQ_W'(item_r.gap);
            fsum_r             <= fsum_r + FSUM_W'(item_r.factor);
            upd_cur_r[seq_idx] <= 1'b1;
            if (run_nxt == RUN_W'(SPAN)) hit_r <= 1'b1;
          end
          state_r <= (item_r.col_end || item_r.prof_end) ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          gap_vec_r    <= {gap_vec_r[WIN-2:0], gaps_r != '0};
          real_r       <= {real_r[HOLD-2:0], 1'b1};
          last_r       <= {last_r[HOLD-2:0], item_r.prof_end};
          hit_vec_r    <= {hit_vec_r[HOLD-2:0], hit_r};
          n_ring_r[0]  <= seq_r;
          g_ring_r[0]  <= gaps_r;
          fs_ring_r[0] <= fsum_r;
          for (int i = 1; i < HOLD; i++) begin
            n_ring_r[i]  <= n_ring_r[i-1];
            g_ring_r[i]  <= g_ring_r[i-1];
            fs_ring_r[i] <= fs_ring_r[i-1];
          end
          seq_r      <= '0;
          gaps_r     <= '0;
          fsum_r     <= '0;
          hit_r      <= 1'b0;
          upd_prev_r <= upd_cur_r;
          upd_cur_r  <= '0;
          flush_r    <= item_r.prof_end ? FLUSH_W'(DELAY) : '0;
          flushing_r <= item_r.prof_end;
          state_r    <= S_EVAL;
        end
        S_EVAL: begin
          if (real_r[DELAY]) begin
            m_r     <= eval_m;
            den_r   <= eval_den;
            ext_r   <= eval_ext;
            lastc_r <= last_r[DELAY];
            state_r <= S_MUL;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL: begin
          rem_r   <= REM_W'(prod[PROD_W-1:QUO_W]);
          quo_r   <= prod[QUO_W-1:0];
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[QUO_W-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QUO_W - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= {(OUT_DW - COL_W - 2 * PEN_W)'(0), ext_r, open_sat, col_r};
            out_last_r  <= lastc_r;
            col_r       <= col_r + 1'b1;
            state_r     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (flush_r != '0) begin
            // push an empty column past the profile end
            gap_vec_r    <= {gap_vec_r[WIN-2:0], 1'b0};
            real_r       <= {real_r[HOLD-2:0], 1'b0};
            last_r       <= {last_r[HOLD-2:0], 1'b0};
            hit_vec_r    <= {hit_vec_r[HOLD-2:0], 1'b0};
            n_ring_r[0]  <= '0;
            g_ring_r[0]  <= '0;
            fs_ring_r[0] <= '0;
            for (int i = 1; i < HOLD; i++) begin
              n_ring_r[i]  <= n_ring_r[i-1];
              g_ring_r[i]  <= g_ring_r[i-1];
              fs_ring_r[i] <= fs_ring_r[i-1];
            end
            flush_r <= flush_r - 1'b1;
            state_r <= S_EVAL;
          end else begin
            if (flushing_r) begin
              gap_vec_r  <= '0;
              real_r     <= '0;
              hit_vec_r  <= '0;
              upd_cur_r  <= '0;
              upd_prev_r <= '0;
              col_r      <= '0;
              flushing_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0)
    else $error("divider started with zero divisor");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < den_r)
    else $error("quotient overflows divider width");
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLOSE |=> (upd_cur_r == '0) && (seq_r == '0))
    else $error("column state not cleared at column close");
`endif

endmodule
